>>> design/etpt_pkg.sv
// Shared types, constants and helper functions of the escape-time projection trap.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package etpt_pkg;

  // Fixed field widths.
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int ITER_W     = 8;
  localparam int SCALE_W    = 16;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Shared multiplier operands and product, and the wide sum width.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 1;

  // Parameter defaults.
  localparam int FRAC_BITS_DEF  = 28;
  localparam int PIXEL_BITS_DEF = 12;

  // Register reset values.
  localparam logic signed [COORD_W-1:0] TRAP_RE_RST = 32'sd67108864;
  localparam logic signed [COORD_W-1:0] TRAP_IM_RST = 32'sd93952410;
  localparam logic [ITER_W-1:0]         ITER_RST    = 8'd50;
  localparam logic [SCALE_W-1:0]        SCALE_RST   = 16'd1280;

  // Coordinate saturation limits.
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_CORNER_RE = 3'd0,
    IDX_CORNER_IM = 3'd1,
    IDX_STEP_RE   = 3'd2,
    IDX_STEP_IM   = 3'd3,
    IDX_TRAP_RE   = 3'd4,
    IDX_TRAP_IM   = 3'd5,
    IDX_MAX_ITER  = 3'd6,
    IDX_OUT_SCALE = 3'd7
  } cfg_idx_e;

  // Configuration seen by the core.
  typedef struct packed {
    logic signed [COORD_W-1:0] corner_re;
    logic signed [COORD_W-1:0] corner_im;
    logic [STEP_W-1:0]         step_re;
    logic [STEP_W-1:0]         step_im;
    logic signed [COORD_W-1:0] trap_re;
    logic signed [COORD_W-1:0] trap_im;
    logic [ITER_W-1:0]         max_iter;
    logic [SCALE_W-1:0]        out_scale;
  } cfg_t;

  // One finished pixel.
  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_end;
  } res_t;

  // Clamp a wide signed sum to the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > SUM_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < SUM_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> design/etpt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on etpt_pkg for the operand and product widths.
`timescale 1ns / 1ps

module etpt_mul (
  input  logic                                clk_i,
  input  logic signed [etpt_pkg::MUL_W-1:0]   a_i,
  input  logic signed [etpt_pkg::MUL_W-1:0]   b_i,
  output logic signed [etpt_pkg::PROD_W-1:0]  prod_o
);
  import etpt_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> design/etpt_scale.sv
// Output scaler: clamps the projection, scales it by the Q8.8 factor and clamps to a byte.
// Depends on etpt_pkg; its two register stages are timed by the core sequencer.
`timescale 1ns / 1ps

module etpt_scale #(
  parameter int FRAC_BITS = etpt_pkg::FRAC_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic signed [etpt_pkg::SUM_W-FRAC_BITS-1:0]    p_i,
  input  logic [etpt_pkg::SCALE_W-1:0]                   scale_i,
  output logic [etpt_pkg::PIX_W-1:0]                     pix_o
);
  import etpt_pkg::*;

  localparam int PW  = SUM_W - FRAC_BITS;
  // Projections at or above 2^(FRAC_BITS+16) saturate the byte for any nonzero scale.
  localparam int PCW = FRAC_BITS + 17;
  localparam int WW  = ((PW > PCW) ? PW : PCW) + 1;
  localparam int MW  = PCW + SCALE_W;
  localparam int VW  = MW - FRAC_BITS - 8;
  localparam logic signed [WW-1:0] P_SAT = WW'(1) << (FRAC_BITS + 16);

  logic signed [WW-1:0] p_w;
  logic [PCW-1:0]       pc_d, pc_q;
  logic [MW-1:0]        prod_q;
  logic [VW-1:0]        v;

  // Stage one: negative projections give zero, large ones are capped.
  assign p_w = WW'(p_i);

  always_comb begin
    if (p_w <= 0) begin
      pc_d = '0;
    end else if (p_w > P_SAT) begin
      pc_d = P_SAT[PCW-1:0];
    end else begin
      pc_d = p_w[PCW-1:0];
    end
  end

  // Stage two: scale by the Q8.8 factor.
  always_ff @(posedge clk_i) begin
    pc_q   <= pc_d;
    prod_q <= MW'(pc_q) * MW'(scale_i);
  end

  // Drop the fraction bits and clamp to the byte range.
  assign v     = prod_q[MW-1:FRAC_BITS+8];
  assign pix_o = (v > VW'(255)) ? PIX_W'(255) : v[PIX_W-1:0];

endmodule

>>> design/etpt_core.sv
// Core sequencer: forms c, runs the orbit on the shared multiplier and tracks the projection.
// Depends on etpt_pkg, etpt_mul and etpt_scale.
`timescale 1ns / 1ps

module etpt_core #(
  parameter int FRAC_BITS  = etpt_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = etpt_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  etpt_pkg::cfg_t          cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [PIXEL_BITS-1:0]   pixel_x_i,
  input  logic [PIXEL_BITS-1:0]   pixel_y_i,
  input  logic                    last_pixel_i,
  output logic                    res_valid_o,
  input  logic                    res_take_i,
  output etpt_pkg::res_t          res_o
);
  import etpt_pkg::*;

  localparam int PW  = SUM_W - FRAC_BITS;
  localparam int PLW = (PW > FRAC_BITS + 4) ? PW : FRAC_BITS + 4;
  localparam logic signed [PLW-1:0] P_LIMIT = PLW'(4) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CR,
    S_CI,
    S_CZ,
    S_P0,
    S_P1,
    S_RR,
    S_II,
    S_RI,
    S_NI,
    S_CLAMP,
    S_SCALE,
    S_DONE
  } state_e;

  state_e                    state_q, state_d;
  logic [ITER_W-1:0]         iter_q, iter_d;
  logic [PIXEL_BITS-1:0]     px_q, px_d, py_q, py_d;
  logic                      last_q, last_d;
  logic signed [COORD_W-1:0] cr_q, cr_d, ci_q, ci_d, zr_q, zr_d, zi_q, zi_d;
  logic signed [SUM_W-1:0]   acc_q, acc_d;
  logic signed [PW-1:0]      p_q, p_d;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   prod_w, cr_sum, ci_sum, p_sum, p_full, nr_sum, ni_sum;
  logic signed [PW-1:0]      p_new;
  logic                      trapped;
  logic [ITER_W:0]           iter_inc;
  logic                      iter_end;
  logic [PIX_W-1:0]          pix;

  // Shared multiplier.
  etpt_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Output scaler, fed by the final projection.
  etpt_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .p_i     (p_q),
    .scale_i (cfg_i.out_scale),
    .pix_o   (pix)
  );

  // Operand selection for the product issued in each state.
  always_comb begin
    case (state_q)
      S_CR: begin
        mul_a = $signed(MUL_W'(px_q));
        mul_b = $signed(MUL_W'(cfg_i.step_re));
      end
      S_CI: begin
        mul_a = $signed(MUL_W'(py_q));
        mul_b = $signed(MUL_W'(cfg_i.step_im));
      end
      S_P0: begin
        mul_a = MUL_W'(zr_q);
        mul_b = MUL_W'(cfg_i.trap_re);
      end
      S_P1: begin
        mul_a = MUL_W'(zi_q);
        mul_b = MUL_W'(cfg_i.trap_im);
      end
      S_II: begin
        mul_a = MUL_W'(zi_q);
        mul_b = MUL_W'(zi_q);
      end
      S_RI: begin
        mul_a = MUL_W'(zr_q);
        mul_b = MUL_W'(zi_q);
      end
      default: begin
        mul_a = MUL_W'(zr_q);
        mul_b = MUL_W'(zr_q);
      end
    endcase
  end

  // Wide sums around the multiplier output.
  assign prod_w   = SUM_W'(prod);
  assign cr_sum   = SUM_W'(cfg_i.corner_re) + prod_w;
  assign ci_sum   = SUM_W'(cfg_i.corner_im) + prod_w;
  assign p_sum    = acc_q + prod_w;
  assign p_full   = p_sum >>> FRAC_BITS;
  assign p_new    = p_full[PW-1:0];
  assign trapped  = PLW'(p_new) >= P_LIMIT;
  assign nr_sum   = (acc_q >>> FRAC_BITS) + SUM_W'(cr_q);
  assign ni_sum   = (prod_w >>> (FRAC_BITS - 1)) + SUM_W'(ci_q);
  assign iter_inc = {1'b0, iter_q} + 1'b1;
  assign iter_end = iter_inc >= {1'b0, cfg_i.max_iter};

  // Sequencer: set-up, orbit steps from S_P0 to S_NI, then scaling.
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    px_d    = px_q;
    py_d    = py_q;
    last_d  = last_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    acc_d   = acc_q;
    p_d     = p_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          px_d    = pixel_x_i;
          py_d    = pixel_y_i;
          last_d  = last_pixel_i;
          iter_d  = '0;
          p_d     = '0;
          state_d = S_CR;
        end
      end
      S_CR: begin
        state_d = S_CI;
      end
      S_CI: begin
        cr_d    = sat_coord(cr_sum);
        zr_d    = sat_coord(cr_sum);
        state_d = S_CZ;
      end
      S_CZ: begin
        ci_d    = sat_coord(ci_sum);
        zi_d    = sat_coord(ci_sum);
        state_d = (cfg_i.max_iter == '0) ? S_CLAMP : S_P0;
      end
      S_P0: begin
        state_d = S_P1;
      end
      S_P1: begin
        acc_d   = prod_w;
        state_d = S_RR;
      end
      S_RR: begin
        // The projection is checked before the step is taken.
        p_d     = p_new;
        state_d = trapped ? S_CLAMP : S_II;
      end
      S_II: begin
        acc_d   = prod_w;
        state_d = S_RI;
      end
      S_RI: begin
        acc_d   = acc_q - prod_w;
        state_d = S_NI;
      end
      S_NI: begin
        zr_d    = sat_coord(nr_sum);
        zi_d    = sat_coord(ni_sum);
        iter_d  = iter_inc[ITER_W-1:0];
        state_d = iter_end ? S_CLAMP : S_P0;
      end
      S_CLAMP: begin
        state_d = S_SCALE;
      end
      S_SCALE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
    cr_q   <= cr_d;
    ci_q   <= ci_d;
    zr_q   <= zr_d;
    zi_q   <= zi_d;
    acc_q  <= acc_d;
    p_q    <= p_d;
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.pixel_value = pix;
  assign res_o.frame_end   = last_q;

endmodule

>>> design/escape_time_projection_trap_top.sv
// Escape-time projection trap, top level: configuration registers, core and output register.
// Flow: set-up, one orbit step per iteration, scaling, then the output register; the orbit
// stops early when the projection reaches 4 and is skipped with a zero iteration limit.
// With one shared multiplier the core takes a new pixel only once the last result has left it.
// Reset (rst_ni, asynchronous, active low) restores register defaults and empties the block.
`timescale 1ns / 1ps

module escape_time_projection_trap_top #(
  parameter int FRAC_BITS  = etpt_pkg::FRAC_BITS_DEF,
  parameter int PIXEL_BITS = etpt_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [etpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [etpt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [PIXEL_BITS-1:0]               pixel_x_i,
  input  logic [PIXEL_BITS-1:0]               pixel_y_i,
  input  logic                                last_pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [etpt_pkg::PIX_W-1:0]          pixel_value_o,
  output logic                                frame_end_o
);
  import etpt_pkg::*;

  cfg_t                cfg_q, cfg_d;
  logic                res_valid, res_take;
  res_t                res;
  logic                out_valid_q, out_valid_d;
  logic [PIX_W-1:0]    pixel_value_q;
  logic                frame_end_q;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        IDX_CORNER_RE: cfg_d.corner_re = $signed(cfg_wdata_i);
        IDX_CORNER_IM: cfg_d.corner_im = $signed(cfg_wdata_i);
        IDX_STEP_RE:   cfg_d.step_re   = cfg_wdata_i[STEP_W-1:0];
        IDX_STEP_IM:   cfg_d.step_im   = cfg_wdata_i[STEP_W-1:0];
        IDX_TRAP_RE:   cfg_d.trap_re   = $signed(cfg_wdata_i);
        IDX_TRAP_IM:   cfg_d.trap_im   = $signed(cfg_wdata_i);
        IDX_MAX_ITER:  cfg_d.max_iter  = cfg_wdata_i[ITER_W-1:0];
        IDX_OUT_SCALE: cfg_d.out_scale = cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.corner_re <= '0;
      cfg_q.corner_im <= '0;
      cfg_q.step_re   <= '0;
      cfg_q.step_im   <= '0;
      cfg_q.trap_re   <= TRAP_RE_RST;
      cfg_q.trap_im   <= TRAP_IM_RST;
      cfg_q.max_iter  <= ITER_RST;
      cfg_q.out_scale <= SCALE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Iteration core.
  etpt_core #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .last_pixel_i (last_pixel_i),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res)
  );

  // Output register: takes a result when empty or when its current transfer completes.
  assign res_take = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      pixel_value_q <= res.pixel_value;
      frame_end_q   <= res.frame_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_value_q;
  assign frame_end_o   = frame_end_q;

endmodule

>>> design/etpt_chk.sv
// Port-level checker for the escape-time projection trap, bound to the top level.
// Depends on etpt_pkg and the top level's ports only; tracks pixels in flight with its own counter.
`timescale 1ns / 1ps

module etpt_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [etpt_pkg::PIX_W-1:0]  pixel_value_o,
  input logic                        frame_end_o
);
  import etpt_pkg::*;

  logic       in_xfer, out_xfer;
  logic [1:0] cnt_q, cnt_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Pixels accepted but not yet delivered.
  always_comb begin
    case ({in_xfer, out_xfer})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The core works on one pixel at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input accepted while previous pixel still in the core");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(frame_end_o))
    else $error("stalled result changed or dropped");

  // No result without a pixel behind it.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != 2'd0))
    else $error("result shown with no pixel in flight");

  // When the core is idle only the output register may hold a pixel.
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q <= 2'd1))
    else $error("core idle with more than one pixel in flight");

  // A pixel entering an empty block cannot appear at the output in the next cycle.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (cnt_q == 2'd0) |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind escape_time_projection_trap_top etpt_chk u_etpt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .pixel_value_o (pixel_value_o),
  .frame_end_o   (frame_end_o)
);

>>> sim/testbench.sv
// Self-checking testbench for the escape-time projection trap top level.
// Needs only etpt_pkg and escape_time_projection_trap_top; an in-bench predictor
// computes the gray level of every accepted pixel and a scoreboard checks the outputs.
`timescale 1ns / 1ps

module testbench;
  import etpt_pkg::*;

  localparam int     FRAC         = FRAC_BITS_DEF;
  localparam int     PXW          = PIXEL_BITS_DEF;
  localparam int     ONE          = 1 << FRAC;
  localparam longint ESC_LIMIT    = longint'(4) <<< FRAC;
  localparam int     CYCLE_LIMIT  = 2000000;
  localparam int     DRAIN_CYCLES = 6 * 255 + 16;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PXW-1:0]        pixel_x_i;
  logic [PXW-1:0]        pixel_y_i;
  logic                  last_pixel_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PIX_W-1:0]      pixel_value_o;
  logic                  frame_end_o;

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;
  int cycles;

  // Predicts the gray level of each accepted pixel and checks results in order.
  class pixel_gray_tracker;
    int          corner_re, corner_im, trap_re, trap_im;
    int unsigned step_re, step_im, max_iter, out_scale;
    res_t        expected_pixels[$];
    int          n_errors;

    function new();
      corner_re = 0;
      corner_im = 0;
      step_re   = 0;
      step_im   = 0;
      trap_re   = TRAP_RE_RST;
      trap_im   = TRAP_IM_RST;
      max_iter  = ITER_RST;
      out_scale = SCALE_RST;
      n_errors  = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > longint'(COORD_MAX)) begin
        return longint'(COORD_MAX);
      end else if (v < longint'(COORD_MIN)) begin
        return longint'(COORD_MIN);
      end
      return v;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        IDX_CORNER_RE: corner_re = v;
        IDX_CORNER_IM: corner_im = v;
        IDX_STEP_RE:   step_re   = 32'(v[STEP_W-1:0]);
        IDX_STEP_IM:   step_im   = 32'(v[STEP_W-1:0]);
        IDX_TRAP_RE:   trap_re   = v;
        IDX_TRAP_IM:   trap_im   = v;
        IDX_MAX_ITER:  max_iter  = 32'(v[ITER_W-1:0]);
        IDX_OUT_SCALE: out_scale = 32'(v[SCALE_W-1:0]);
        default: ;
      endcase
    endfunction

    // Runs the orbit of one pixel and queues its expected result.
    function void note_pixel(logic [PXW-1:0] px, logic [PXW-1:0] py, logic last);
      longint              cr, ci, zr, zi, nr, ni, proj, scaled;
      logic signed [69:0]  dot;
      res_t                res;
      int unsigned         i;
      cr   = clamp32(longint'(corner_re) + longint'(px) * longint'(step_re));
      ci   = clamp32(longint'(corner_im) + longint'(py) * longint'(step_im));
      zr   = cr;
      zi   = ci;
      proj = 0;
      for (i = 0; i < max_iter; i++) begin
        // The dot product needs more than 64 bits before the shift.
        dot  = zr * longint'(trap_re) + zi * longint'(trap_im);
        proj = longint'(dot >>> FRAC);
        if (proj >= ESC_LIMIT) break;
        nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
        ni = ((zr * zi) >>> (FRAC - 1)) + ci;
        zr = clamp32(nr);
        zi = clamp32(ni);
      end
      if (proj <= 0) begin
        res.pixel_value = '0;
      end else begin
        scaled = ((proj * out_scale) >> 8) >> FRAC;
        res.pixel_value = (scaled > 255) ? 8'd255 : scaled[7:0];
      end
      res.frame_end = last;
      expected_pixels.push_back(res);
    endfunction

    function void flag(string what, int expv, int actv);
      n_errors++;
      if (n_errors <= 10) begin
        $display("MISMATCH %s: expected %0d, got %0d", what, expv, actv);
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] value, logic fe);
      res_t want;
      if (expected_pixels.size() == 0) begin
        flag("pixel with none pending", 0, int'(value));
        return;
      end
      want = expected_pixels.pop_front();
      if (value !== want.pixel_value) begin
        flag("pixel_value", int'(want.pixel_value), int'(value));
      end
      if (fe !== want.frame_end) flag("frame_end", int'(want.frame_end), int'(fe));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  pixel_gray_tracker sb;

  escape_time_projection_trap_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .last_pixel_i  (last_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .frame_end_o   (frame_end_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run-length guard.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Output side: random stalls, an optional long hold-off, and result checks.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_pixel(pixel_value_o, frame_end_o);
    end
  end

  // Writes one register; the block is idle whenever this is called.
  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_view(logic [31:0] cre, logic [31:0] cim, logic [31:0] sre,
                          logic [31:0] sim, logic [31:0] tre, logic [31:0] tim,
                          logic [31:0] iter, logic [31:0] scale);
    set_reg(IDX_CORNER_RE, cre);
    set_reg(IDX_CORNER_IM, cim);
    set_reg(IDX_STEP_RE, sre);
    set_reg(IDX_STEP_IM, sim);
    set_reg(IDX_TRAP_RE, tre);
    set_reg(IDX_TRAP_IM, tim);
    set_reg(IDX_MAX_ITER, iter);
    set_reg(IDX_OUT_SCALE, scale);
  endtask

  // Offers one pixel after a random gap and waits for its transfer.
  task automatic send_pixel(logic [PXW-1:0] px, logic [PXW-1:0] py, logic last);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_x_i    <= px;
    pixel_y_i    <= py;
    last_pixel_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(px, py, last);
  endtask

  // Drops valid and waits until every pending pixel has come out.
  task automatic finish_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly small raster frames closed by last_pixel, mixed with stray pixels.
  task automatic run_phase(int n_items, int idle, int stall);
    int sent, w, h, x0, y0, r, c;
    tx_idle_pct  = idle;
    rx_stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(4) == 0) begin
        send_pixel(PXW'($urandom), PXW'($urandom), 1'($urandom_range(1)));
        sent++;
      end else begin
        w  = $urandom_range(1, 8);
        h  = $urandom_range(1, 6);
        x0 = $urandom_range(4095);
        y0 = $urandom_range(4095);
        // The last frame of a phase is cut down to the items still owed.
        if (w * h > n_items - sent) begin
          w = n_items - sent;
          h = 1;
        end
        for (r = 0; r < h; r++) begin
          for (c = 0; c < w; c++) begin
            send_pixel(PXW'(x0 + c), PXW'(y0 + r), (r == h - 1) && (c == w - 1));
            sent++;
          end
        end
      end
    end
    finish_burst();
  endtask

  // Random view over the interesting part of the plane.
  task automatic random_view();
    logic [31:0] cre, cim, sre, sim, tre, tim, iter, scale;
    int          pick;
    cre = -671088640 + $urandom_range(939524096);
    cim = -402653184 + $urandom_range(805306368);
    sre = {1'($urandom_range(1)),
           31'($urandom_range(($urandom_range(3) == 0) ? 262144 : 65536))};
    sim = {1'($urandom_range(1)),
           31'($urandom_range(($urandom_range(3) == 0) ? 262144 : 65536))};
    tre = $urandom_range(1073741824) - 536870912;
    tim = $urandom_range(1073741824) - 536870912;
    if ($urandom_range(9) == 0) sre = $urandom;
    if ($urandom_range(9) == 0) tim = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) begin
      iter = 0;
    end else if (pick < 75) begin
      iter = $urandom_range(1, 12);
    end else begin
      iter = $urandom_range(13, 40);
    end
    scale = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2047);
    set_view(cre, cim, sre, sim, tre, tim, iter, scale);
  endtask

  // Main sequence: reset, directed cases, then random phases.
  initial begin
    int ph;
    sb           = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    pixel_x_i    = '0;
    pixel_y_i    = '0;
    last_pixel_i = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults straight after reset.
    send_pixel(0, 0, 0);
    send_pixel(4095, 4095, 1);
    finish_burst();

    // A classic view: corners, center and alternating bit patterns.
    set_view(-2 * ONE, -335544320, 131072, 131072, TRAP_RE_RST, TRAP_IM_RST,
             ITER_RST, SCALE_RST);
    send_pixel(0, 0, 0);
    send_pixel(4095, 0, 0);
    send_pixel(0, 4095, 0);
    send_pixel(4095, 4095, 0);
    send_pixel(2048, 2048, 0);
    send_pixel(12'hAAA, 12'h555, 1);
    send_pixel(12'h555, 12'hAAA, 0);
    finish_burst();

    // Zero iteration limit gives black pixels.
    set_reg(IDX_MAX_ITER, 0);
    send_pixel(100, 200, 1);
    send_pixel(4095, 0, 0);
    finish_burst();

    // A trap direction with both components negative.
    set_reg(IDX_TRAP_RE, -ONE);
    set_reg(IDX_TRAP_IM, -ONE);
    set_reg(IDX_MAX_ITER, 8);
    send_pixel(3000, 3000, 0);
    send_pixel(4000, 1000, 1);
    finish_burst();

    // Upper extremes: saturated c, escape on the first projection.
    set_view(COORD_MAX, COORD_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, COORD_MAX, COORD_MAX,
             255, 65535);
    send_pixel(4095, 4095, 1);
    send_pixel(0, 0, 0);
    finish_burst();

    // Lower extremes: zero scale, then a projection wider than 64 bits.
    set_view(COORD_MIN, COORD_MIN, 0, 0, COORD_MIN, COORD_MAX, 1, 0);
    send_pixel(1, 2, 0);
    send_pixel(4095, 4095, 1);
    finish_burst();
    set_reg(IDX_TRAP_IM, COORD_MIN);
    set_reg(IDX_OUT_SCALE, 256);
    send_pixel(0, 0, 1);
    finish_burst();

    // Deep inside the set at the full iteration limit.
    set_view(-67108864, -67108864, 4096, 4096, TRAP_RE_RST, TRAP_IM_RST, 255, SCALE_RST);
    run_phase(12, 28, 28);

    // Random views under every idling mix.
    for (ph = 0; ph < 34; ph++) begin
      random_view();
      if (ph == 4) begin
        // Long receiver hold-off while the sender keeps offering pixels.
        set_reg(IDX_MAX_ITER, 3);
        rx_hold_left = 3000;
      end
      case (ph % 4)
        0: run_phase(50, 0, 0);
        1: run_phase(50, 61, 0);
        2: run_phase(50, 0, 61);
        default: run_phase(50, 28, 28);
      endcase
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.flag("pixels still pending at end", 0, sb.pending());
    if (sb.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/etpt_pkg.sv
design/etpt_mul.sv
design/etpt_scale.sv
design/etpt_core.sv
design/escape_time_projection_trap_top.sv
design/etpt_chk.sv
sim/testbench.sv
